// File: design/scwe_pkg.sv
package scwe_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int HEIGHT_W = 16;
    localparam int RUN_W    = 18;
    localparam int CALC_W   = 19;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = 6;
    localparam int TYPE_W   = 8;
    localparam int FLAGS_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = 7'd64;

    typedef enum logic [1:0] {
        PH_GAP,
        PH_SPAN,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic   accept;
        logic   calc;
        logic   emit;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic slot_free;
        logic last_item;
    } status_t;

endpackage

// File: design/scwe_ctrl.sv
module scwe_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  scwe_pkg::status_t status,
    output scwe_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_GAP,
        ST_SPAN,
        ST_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.calc   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.phase  = scwe_pkg::PH_GAP;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_GAP;
            end
            ST_GAP:
            begin
                cmd.phase = scwe_pkg::PH_GAP;
                cmd.emit  = status.more && status.slot_free;
                if (!status.more)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                cmd.phase = scwe_pkg::PH_SPAN;
                cmd.emit  = status.more && status.slot_free;
                if (!status.more)
                begin
                    state_next = status.last_item ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                cmd.phase = scwe_pkg::PH_TAIL;
                cmd.emit  = status.more && status.slot_free;
                if (!status.more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// File: design/scwe_datapath.sv
module scwe_datapath
#(
    parameter int WINDOW_MAX = scwe_pkg::WINDOW_MAX_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [scwe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scwe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [scwe_pkg::HEIGHT_W-1:0] window_start,
    input  logic [scwe_pkg::HEIGHT_W-1:0]        span_height,
    input  logic [scwe_pkg::TYPE_W-1:0]          span_type,
    input  logic [scwe_pkg::FLAGS_W-1:0]         span_flags,
    input  logic                                 has_span,
    input  logic                                 last_span,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [scwe_pkg::IDX_W-1:0]           cell_index,
    output logic [scwe_pkg::TYPE_W-1:0]          cell_type,
    output logic [scwe_pkg::FLAGS_W-1:0]         cell_flags,
    output logic                                 last_cell,
    input  scwe_pkg::cmd_t                       cmd,
    output scwe_pkg::status_t                    status
);

    localparam int LEN_W  = scwe_pkg::LEN_W;
    localparam int CALC_W = scwe_pkg::CALC_W;
    localparam int RUN_W  = scwe_pkg::RUN_W;
    localparam int HW     = scwe_pkg::HEIGHT_W;

    logic signed [HW-1:0]              base_reg;
    logic [LEN_W-1:0]                  wlen_reg;
    logic signed [HW-1:0]              held_start_reg;
    logic [LEN_W-1:0]                  held_len_reg;
    logic signed [RUN_W-1:0]           run_pos_reg;
    logic [LEN_W-1:0]                  next_cell_reg;
    logic                              open_reg;
    logic                              passed_reg;
    logic [HW-1:0]                     height_reg;
    logic [scwe_pkg::TYPE_W-1:0]       type_reg;
    logic [scwe_pkg::FLAGS_W-1:0]      flags_reg;
    logic                              has_reg;
    logic                              last_reg;
    logic [LEN_W-1:0]                  gap_end_reg;
    logic [LEN_W-1:0]                  span_end_reg;
    logic                              out_valid_reg;
    logic [scwe_pkg::IDX_W-1:0]        cell_index_reg;
    logic [scwe_pkg::TYPE_W-1:0]       cell_type_reg;
    logic [scwe_pkg::FLAGS_W-1:0]      cell_flags_reg;
    logic                              last_cell_reg;

    logic [LEN_W-1:0]        len_clamped;
    logic signed [CALC_W-1:0] z0;
    logic signed [CALC_W-1:0] z1;
    logic signed [CALC_W-1:0] zs;
    logic signed [CALC_W-1:0] zl;
    logic signed [CALC_W-1:0] j0;
    logic signed [CALC_W-1:0] j1;
    logic signed [CALC_W-1:0] len_ext;
    logic                     active;
    logic                     hit;
    logic [LEN_W-1:0]         j0_clip;
    logic [LEN_W-1:0]         j1_clip;
    logic [LEN_W-1:0]         end_sel;
    logic [LEN_W-1:0]         cell_plus;
    logic                     slot_free;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (wlen_reg > LEN_W'(WINDOW_MAX))
        begin
            len_clamped = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_clamped = wlen_reg;
        end
    end

    always_comb
    begin
        len_ext = CALC_W'({1'b0, held_len_reg});
        z0      = CALC_W'(run_pos_reg);
        z1      = z0 + CALC_W'({1'b0, height_reg});
        zs      = CALC_W'(held_start_reg);
        zl      = zs + len_ext;
        j0      = z0 - zs;
        j1      = z1 - zs;
        active  = has_reg && !passed_reg;
        hit     = active && (z0 < zl) && (z1 > zs);
        j0_clip = (j0 < 0) ? '0 : j0[LEN_W-1:0];
        j1_clip = (j1 > len_ext) ? held_len_reg : j1[LEN_W-1:0];
    end

    always_comb
    begin
        case (cmd.phase)
            scwe_pkg::PH_GAP:  end_sel = gap_end_reg;
            scwe_pkg::PH_SPAN: end_sel = span_end_reg;
            scwe_pkg::PH_TAIL: end_sel = held_len_reg;
            default:           end_sel = '0;
        endcase
    end

    assign cell_plus        = next_cell_reg + LEN_W'(1);
    assign slot_free        = !out_valid_reg || !out_stall;
    assign status.more      = next_cell_reg < end_sel;
    assign status.slot_free = slot_free;
    assign status.last_item = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            wlen_reg       <= scwe_pkg::WINDOW_LENGTH_RST;
            held_start_reg <= '0;
            held_len_reg   <= '0;
            run_pos_reg    <= '0;
            next_cell_reg  <= '0;
            open_reg       <= 1'b0;
            passed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    scwe_pkg::REG_BASE_HEIGHT:   base_reg <= cfg_data;
                    scwe_pkg::REG_WINDOW_LENGTH: wlen_reg <= cfg_data[LEN_W-1:0];
                    default:                     ;
                endcase
            end

            if (cmd.accept && !open_reg)
            begin
                held_len_reg   <= len_clamped;
                held_start_reg <= window_start;
                run_pos_reg    <= RUN_W'(base_reg);
                next_cell_reg  <= '0;
                passed_reg     <= 1'b0;
                open_reg       <= 1'b1;
            end

            if (cmd.calc)
            begin
                if (active)
                begin
                    run_pos_reg <= z1[RUN_W-1:0];
                    if (z1 >= zl)
                    begin
                        passed_reg <= 1'b1;
                    end
                end
                if (last_reg)
                begin
                    open_reg <= 1'b0;
                end
            end

            if (cmd.emit)
            begin
                next_cell_reg <= cell_plus;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            height_reg <= span_height;
            type_reg   <= span_type;
            flags_reg  <= span_flags;
            has_reg    <= has_span;
            last_reg   <= last_span;
        end
        if (cmd.calc)
        begin
            gap_end_reg  <= hit ? j0_clip : '0;
            span_end_reg <= hit ? j1_clip : '0;
        end
        if (cmd.emit)
        begin
            cell_index_reg <= next_cell_reg[scwe_pkg::IDX_W-1:0];
            last_cell_reg  <= (cell_plus == held_len_reg);
            if (cmd.phase == scwe_pkg::PH_SPAN)
            begin
                cell_type_reg  <= type_reg;
                cell_flags_reg <= flags_reg;
            end
            else
            begin
                cell_type_reg  <= '0;
                cell_flags_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_index = cell_index_reg;
    assign cell_type  = cell_type_reg;
    assign cell_flags = cell_flags_reg;
    assign last_cell  = last_cell_reg;

endmodule

// File: design/span_column_window_expander.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | window_start span_height span_type span_flags
//         |                      | has_span last_span
// out     | out_valid/out_stall  | cell_index cell_type cell_flags last_cell
// cfg     | cfg_we               | cfg_index cfg_data
//
// A transaction passes through accept and bounds steps, then emits its cells in a gap
// phase, a span phase and, on a column's last item, a tail phase; the single output
// register and the shared cell counter allow one cell per cycle unless out_stall holds it.
// Reset (rst_n low, async) closes any column; window_length resets to 64.
// in_stall is high from the cycle after acceptance until the last phase closes;
// out_stall holds a valid cell in the output register and pauses cell emission.
module span_column_window_expander
#(
    parameter int WINDOW_MAX = scwe_pkg::WINDOW_MAX_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [scwe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scwe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [scwe_pkg::HEIGHT_W-1:0] window_start,
    input  logic [scwe_pkg::HEIGHT_W-1:0]        span_height,
    input  logic [scwe_pkg::TYPE_W-1:0]          span_type,
    input  logic [scwe_pkg::FLAGS_W-1:0]         span_flags,
    input  logic                                 has_span,
    input  logic                                 last_span,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [scwe_pkg::IDX_W-1:0]           cell_index,
    output logic [scwe_pkg::TYPE_W-1:0]          cell_type,
    output logic [scwe_pkg::FLAGS_W-1:0]         cell_flags,
    output logic                                 last_cell
);

    scwe_pkg::cmd_t    cmd;
    scwe_pkg::status_t status;

    scwe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    scwe_datapath
    #(
        .WINDOW_MAX (WINDOW_MAX)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .window_start (window_start),
        .span_height  (span_height),
        .span_type    (span_type),
        .span_flags   (span_flags),
        .has_span     (has_span),
        .last_span    (last_span),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .cell_index   (cell_index),
        .cell_type    (cell_type),
        .cell_flags   (cell_flags),
        .last_cell    (last_cell),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int HEIGHT_W   = scwe_pkg::HEIGHT_W;
    localparam int TYPE_W     = scwe_pkg::TYPE_W;
    localparam int FLAGS_W    = scwe_pkg::FLAGS_W;
    localparam int IDX_W      = scwe_pkg::IDX_W;
    localparam int LEN_W      = scwe_pkg::LEN_W;
    localparam int CFG_IDX_W  = scwe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = scwe_pkg::CFG_DATA_W;

    localparam int WIN_MAX       = scwe_pkg::WINDOW_MAX_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 35;

    typedef struct packed {
        logic [HEIGHT_W-1:0] ws;
        logic [HEIGHT_W-1:0] height;
        logic [TYPE_W-1:0]   ty;
        logic [FLAGS_W-1:0]  fl;
        logic                hs;
        logic                ls;
    } span_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [TYPE_W-1:0]  ty;
        logic [FLAGS_W-1:0] fl;
        logic               last;
    } cell_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        span_item_t            item;
        int                    known_cnt;   // -1: cells come from the predictor
        int                    known_first;
        logic [TYPE_W-1:0]     known_ty;
        logic [FLAGS_W-1:0]    known_fl;
        logic                  known_last;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [HEIGHT_W-1:0]   window_start;
    logic [HEIGHT_W-1:0]          span_height;
    logic [TYPE_W-1:0]            span_type;
    logic [FLAGS_W-1:0]           span_flags;
    logic                         has_span;
    logic                         last_span;
    logic                         out_valid;
    logic                         out_stall;
    logic [IDX_W-1:0]             cell_index;
    logic [TYPE_W-1:0]            cell_type;
    logic [FLAGS_W-1:0]           cell_flags;
    logic                         last_cell;

    cell_t       cells_due[$];
    cell_t       step_cells[$];
    stim_row_t   directed_rows[$];
    cell_t       due_cell;

    // predictor copy of registers and column state
    logic signed [HEIGHT_W-1:0] base_reg;
    logic [LEN_W-1:0]           length_reg;
    int                         run_pos;
    int                         held_ws;
    int                         next_cell;
    int                         held_len;
    bit                         col_open;
    bit                         win_passed;

    int          mismatches;
    int          burst_left;
    int          quiet_cycles;
    bit          hold_req;
    bit          hold_done;
    stall_mode_t stall_mode;
    int          stall_left;
    int          stall_tick;

    span_column_window_expander u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .window_start (window_start),
        .span_height  (span_height),
        .span_type    (span_type),
        .span_flags   (span_flags),
        .has_span     (has_span),
        .last_span    (last_span),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_index   (cell_index),
        .cell_type    (cell_type),
        .cell_flags   (cell_flags),
        .last_cell    (last_cell)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void emit_upto(int stop, logic [TYPE_W-1:0] ty, logic [FLAGS_W-1:0] fl);
        cell_t c;
        if (stop > held_len)
            stop = held_len;
        while (next_cell < stop)
        begin
            c.idx  = IDX_W'(next_cell);
            c.ty   = ty;
            c.fl   = fl;
            c.last = (next_cell + 1 == held_len);
            step_cells = {step_cells, c};
            next_cell++;
        end
    endfunction

    function automatic void expand_item(span_item_t it);
        int lo;
        int hi;
        int win_lo;
        int win_hi;
        int j0;
        int j1;
        if (!col_open)
        begin
            if (length_reg == 0)
                held_len = 1;
            else if (int'(length_reg) > WIN_MAX)
                held_len = WIN_MAX;
            else
                held_len = int'(length_reg);
            held_ws    = int'($signed(it.ws));
            run_pos    = int'(base_reg);
            next_cell  = 0;
            win_passed = 1'b0;
            col_open   = 1'b1;
        end
        if (it.hs && !win_passed)
        begin
            lo     = run_pos;
            hi     = lo + int'(it.height);
            win_lo = held_ws;
            win_hi = held_ws + held_len;
            if (lo < win_hi && hi > win_lo)
            begin
                j0 = lo - win_lo;
                j1 = hi - win_lo;
                if (j0 < 0)
                    j0 = 0;
                if (j1 > held_len)
                    j1 = held_len;
                emit_upto(j0, '0, '0);
                emit_upto(j1, it.ty, it.fl);
            end
            run_pos = hi;
            if (hi >= win_hi)
                win_passed = 1'b1;
        end
        if (it.ls)
        begin
            emit_upto(held_len, '0, '0);
            col_open = 1'b0;
        end
    endfunction

    function automatic span_item_t random_item();
        span_item_t it;
        it.ws     = 16'($urandom());
        it.height = 16'($urandom());
        it.ty     = 8'($urandom());
        it.fl     = 8'($urandom());
        it.hs     = 1'($urandom());
        it.ls     = 1'($urandom());
        return it;
    endfunction

    function automatic void add_item(logic [15:0] ws, logic [15:0] height, logic [7:0] ty,
                                     logic [7:0] fl, bit hs, bit ls, int known_cnt,
                                     int known_first, logic [7:0] known_ty,
                                     logic [7:0] known_fl, bit known_last);
        stim_row_t r;
        r.kind        = ROW_ITEM;
        r.reg_idx     = '0;
        r.reg_val     = '0;
        r.item        = {ws, height, ty, fl, hs, ls};
        r.known_cnt   = known_cnt;
        r.known_first = known_first;
        r.known_ty    = known_ty;
        r.known_fl    = known_fl;
        r.known_last  = known_last;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r.kind        = ROW_CFG;
        r.reg_idx     = idx;
        r.reg_val     = val;
        r.item        = '0;
        r.known_cnt   = 0;
        r.known_first = 0;
        r.known_ty    = '0;
        r.known_fl    = '0;
        r.known_last  = 1'b0;
        directed_rows = {directed_rows, r};
    endfunction

    // offers one transaction, holds it until accepted, then predicts its cells
    task automatic offer(span_item_t it, bit use_model);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(5, 12)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid     <= 1'b1;
        window_start <= it.ws;
        span_height  <= it.height;
        span_type    <= it.ty;
        span_flags   <= it.fl;
        has_span     <= it.hs;
        last_span    <= it.ls;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_cells.delete();
        expand_item(it);
        if (use_model)
            foreach (step_cells[i])
                cells_due = {cells_due, step_cells[i]};
    endtask

    task automatic wait_drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == scwe_pkg::REG_BASE_HEIGHT)
            base_reg = val;
        else
            length_reg = val[LEN_W-1:0];
        @(posedge clk);
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        stall_left = 0;
        stall_tick = 0;
        hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    stall_left = $urandom_range(8, 60);
                end
                stall_left--;
                stall_tick++;
                case (stall_mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
                    default:        out_stall <= (stall_tick % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (cells_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: cell expected none, actual index %0d type %0h flags %0h",
                         $time, cell_index, cell_type, cell_flags);
            end
            else
            begin
                due_cell = cells_due.pop_front();
                if (cell_index !== due_cell.idx)
                begin
                    mismatches++;
                    $display("%0t: cell_index expected %0d actual %0d",
                             $time, due_cell.idx, cell_index);
                end
                if (cell_type !== due_cell.ty)
                begin
                    mismatches++;
                    $display("%0t: cell_type expected %0h actual %0h",
                             $time, due_cell.ty, cell_type);
                end
                if (cell_flags !== due_cell.fl)
                begin
                    mismatches++;
                    $display("%0t: cell_flags expected %0h actual %0h",
                             $time, due_cell.fl, cell_flags);
                end
                if (last_cell !== due_cell.last)
                begin
                    mismatches++;
                    $display("%0t: last_cell expected %0b actual %0b",
                             $time, due_cell.last, last_cell);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        stim_row_t             row;
        cell_t                 c;
        span_item_t            it;
        logic [HEIGHT_W-1:0]   col_ws;
        logic [CFG_DATA_W-1:0] reg_val;
        int                    sent;
        int                    nspan;
        int                    kind;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        window_start <= '0;
        span_height  <= '0;
        span_type    <= '0;
        span_flags   <= '0;
        has_span     <= 1'b0;
        last_span    <= 1'b0;
        burst_left   = 0;
        hold_req     = 1'b0;
        base_reg     = '0;
        length_reg   = scwe_pkg::WINDOW_LENGTH_RST;
        col_open     = 1'b0;
        win_passed   = 1'b0;
        run_pos      = 0;
        held_ws      = 0;
        next_cell    = 0;
        held_len     = 0;

        // empty column at reset settings: whole window of zero cells
        add_item(16'h0000, 16'h0000, 8'h00, 8'h00, 0, 1, 64, 0, 8'h00, 8'h00, 1);
        add_cfg(scwe_pkg::REG_WINDOW_LENGTH, 16'd8);
        add_item(16'h0000, 16'h0003, 8'hFF, 8'hFF, 1, 0, 3, 0, 8'hFF, 8'hFF, 0);
        // window start of a later item is not taken
        add_item(16'hFFFF, 16'h0002, 8'h5A, 8'hA5, 1, 0, 2, 3, 8'h5A, 8'hA5, 0);
        add_item(16'h0000, 16'h0000, 8'h77, 8'h77, 1, 0, 0, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'hFFFF, 8'h01, 8'h80, 1, 1, 3, 5, 8'h01, 8'h80, 1);
        // item without span opens the column; spans above the window top
        add_item(16'h8000, 16'h0000, 8'h00, 8'h00, 0, 0, 0, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'h0005, 8'h11, 8'h22, 1, 0, 0, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'h0001, 8'h33, 8'h44, 1, 1, 8, 0, 8'h00, 8'h00, 1);
        add_cfg(scwe_pkg::REG_BASE_HEIGHT, 16'h8000);
        add_cfg(scwe_pkg::REG_WINDOW_LENGTH, 16'd1);
        add_item(16'h8000, 16'h0001, 8'hA5, 8'h5A, 1, 1, 1, 0, 8'hA5, 8'h5A, 1);
        add_cfg(scwe_pkg::REG_BASE_HEIGHT, 16'h7FFF);
        add_cfg(scwe_pkg::REG_WINDOW_LENGTH, 16'd0);
        add_item(16'h7FFF, 16'hFFFF, 8'hC3, 8'h3C, 1, 1, 1, 0, 8'hC3, 8'h3C, 1);
        add_cfg(scwe_pkg::REG_WINDOW_LENGTH, 16'hFF7F);
        add_item(16'h7FC0, 16'h0001, 8'h96, 8'h69, 1, 0, -1, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'h000A, 8'hFF, 8'hFF, 1, 1, 0, 0, 8'h00, 8'h00, 0);
        add_cfg(scwe_pkg::REG_BASE_HEIGHT, 16'h0000);
        add_cfg(scwe_pkg::REG_WINDOW_LENGTH, 16'd64);
        add_item(16'hFFFE, 16'h0004, 8'h12, 8'h34, 1, 0, -1, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'h0000, 8'h00, 8'h00, 0, 0, -1, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'd60,   8'h56, 8'h78, 1, 0, -1, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'h0003, 8'hAB, 8'hCD, 1, 1, -1, 0, 8'h00, 8'h00, 0);
        // span wholly below the window, then one crossing its bottom
        add_item(16'd100,  16'd50,   8'h21, 8'h43, 1, 0, -1, 0, 8'h00, 8'h00, 0);
        add_item(16'h0000, 16'd60,   8'h65, 8'h87, 1, 1, -1, 0, 8'h00, 8'h00, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drain();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                offer(row.item, row.known_cnt < 0);
                for (int k = 0; k < row.known_cnt; k++)
                begin
                    c.idx  = IDX_W'(row.known_first + k);
                    c.ty   = row.known_ty;
                    c.fl   = row.known_fl;
                    c.last = row.known_last && (k == row.known_cnt - 1);
                    cells_due = {cells_due, c};
                end
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drain();
            case ($urandom_range(0, 3))
                0:       reg_val = 16'h8000;
                1:       reg_val = 16'h7FF0;
                2:       reg_val = 16'h0000;
                default: reg_val = 16'($urandom());
            endcase
            write_reg(scwe_pkg::REG_BASE_HEIGHT, reg_val);
            reg_val = 16'($urandom());
            case ($urandom_range(0, 5))
                0:       reg_val[LEN_W-1:0] = 7'd0;
                1:       reg_val[LEN_W-1:0] = 7'd64;
                2:       reg_val[LEN_W-1:0] = 7'd127;
                default: reg_val[LEN_W-1:0] = 7'($urandom_range(1, 12));
            endcase
            write_reg(scwe_pkg::REG_WINDOW_LENGTH, reg_val);
            if (p == 1)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                begin
                    it    = random_item();
                    it.hs = 1'b0;
                    it.ls = 1'b1;
                    offer(it, 1'b1);
                    sent++;
                end
                else if (kind == 1)
                begin
                    offer(random_item(), 1'b1);
                    sent++;
                end
                else
                begin
                    col_ws = base_reg + 16'($urandom_range(0, 24)) - 16'd12;
                    if ($urandom_range(0, 9) == 0)
                        col_ws = 16'($urandom());
                    if ($urandom_range(0, 7) == 0)
                    begin
                        it    = random_item();
                        it.ws = col_ws;
                        it.hs = 1'b0;
                        it.ls = 1'b0;
                        offer(it, 1'b1);
                    end
                    nspan = $urandom_range(1, 6);
                    for (int k = 0; k < nspan; k++)
                    begin
                        it    = random_item();
                        it.ws = col_ws;
                        it.hs = 1'b1;
                        // now and then the column is left open into the next one
                        it.ls = (k == nspan - 1) && ($urandom_range(0, 11) != 0);
                        case ($urandom_range(0, 9))
                            0:       it.height = '0;
                            1:       it.height = 16'($urandom_range(7, 40));
                            2:       ;
                            default: it.height = 16'($urandom_range(1, 6));
                        endcase
                        offer(it, 1'b1);
                        sent++;
                    end
                end
                if ($urandom_range(0, 24) == 0)
                    wait_drain();
            end
        end

        wait_drain();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && cells_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
